### design/rgbrms_pkg.sv
// Shared types and constants for the RGB RMS image difference block.
`timescale 1ns / 1ps
package rgbrms_pkg;

    localparam int unsigned MAX_PIXELS = 1048576;
    localparam int unsigned PAIRS_W    = 21;
    localparam int unsigned PAIRS_MAX  = 2097151;
    localparam int unsigned PAIR_CAP   = (MAX_PIXELS < PAIRS_MAX) ? MAX_PIXELS : PAIRS_MAX;
    localparam int unsigned SUM_W      = 38;
    localparam int unsigned DIST_W     = 18;
    localparam int unsigned DIST_MAX   = 195075;
    localparam int unsigned DIVISOR_W  = PAIRS_W + 2;
    localparam int unsigned NUM_W      = SUM_W + 16;
    localparam int unsigned ROOT_W     = NUM_W / 2;
    localparam int unsigned SQREM_W    = ROOT_W + 1;
    localparam int unsigned RMS_W      = 16;
    localparam int unsigned FULL_SCALE = 65280;
    localparam int unsigned DIV_STEPS  = NUM_W;
    localparam int unsigned ROOT_STEPS = ROOT_W;
    localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_ACC,
        ST_LOAD,
        ST_DIV,
        ST_ROOT,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accumulate;
        logic capture;
        logic div_step;
        logic root_step;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pairs_zero;
        logic out_busy;
    } sts_t;

endpackage

### design/rgb_rms_image_difference.sv
// Sequence: a request with last set starts the result once it is accepted
// (capture, 54 divide steps, 27 root steps, output load); an empty frame goes from capture to output load.
// Throughput: one request per cycle while a frame accumulates; the serial divider
// and root then hold the input off at each frame end (an empty frame only for capture and
// output load), and longer while the previous result still waits in the output register.
// Reset: rst_n is asynchronous, clears the accumulators, state machine and output valid.
`timescale 1ns / 1ps
module rgb_rms_image_difference (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          red_a,
    input  logic [7:0]                          green_a,
    input  logic [7:0]                          blue_a,
    input  logic [7:0]                          red_b,
    input  logic [7:0]                          green_b,
    input  logic [7:0]                          blue_b,
    input  logic                                compare,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rgbrms_pkg::RMS_W-1:0]        rms_scaled,
    output logic [rgbrms_pkg::DIST_W-1:0]       peak_sq_dist,
    output logic [rgbrms_pkg::PAIRS_W-1:0]      pair_count,
    output logic                                no_overlap
);

    rgbrms_pkg::cmd_t cmd;
    rgbrms_pkg::sts_t sts;

    rgbrms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .compare  (compare),
        .last     (last),
        .sts      (sts),
        .cmd      (cmd)
    );

    rgbrms_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .red_a        (red_a),
        .green_a      (green_a),
        .blue_a       (blue_a),
        .red_b        (red_b),
        .green_b      (green_b),
        .blue_b       (blue_b),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .rms_scaled   (rms_scaled),
        .peak_sq_dist (peak_sq_dist),
        .pair_count   (pair_count),
        .no_overlap   (no_overlap)
    );

endmodule

### design/rgbrms_dp.sv
// Datapath: per-pair distance, frame accumulators, serial divider and square root.
`timescale 1ns / 1ps
module rgbrms_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rgbrms_pkg::cmd_t                    cmd,
    output rgbrms_pkg::sts_t                    sts,
    input  logic [7:0]                          red_a,
    input  logic [7:0]                          green_a,
    input  logic [7:0]                          blue_a,
    input  logic [7:0]                          red_b,
    input  logic [7:0]                          green_b,
    input  logic [7:0]                          blue_b,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [rgbrms_pkg::RMS_W-1:0]        rms_scaled,
    output logic [rgbrms_pkg::DIST_W-1:0]       peak_sq_dist,
    output logic [rgbrms_pkg::PAIRS_W-1:0]      pair_count,
    output logic                                no_overlap
);

    function automatic logic [15:0] chan_sq(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] d;
        begin
            d = (x > y) ? (x - y) : (y - x);
            chan_sq = 16'(d) * 16'(d);
        end
    endfunction

    // frame accumulators
    logic [rgbrms_pkg::SUM_W-1:0]     sum_reg;
    logic [rgbrms_pkg::DIST_W-1:0]    peak_reg;
    logic [rgbrms_pkg::PAIRS_W-1:0]   pairs_reg;

    // result engine
    logic [rgbrms_pkg::NUM_W-1:0]     nq_reg;
    logic [rgbrms_pkg::DIVISOR_W-1:0] divisor_reg;
    logic [rgbrms_pkg::DIVISOR_W-1:0] div_rem_reg;
    logic [rgbrms_pkg::ROOT_W-1:0]    root_reg;
    logic [rgbrms_pkg::SQREM_W-1:0]   sq_rem_reg;
    logic [rgbrms_pkg::DIST_W-1:0]    peak_hold_reg;
    logic [rgbrms_pkg::PAIRS_W-1:0]   pairs_hold_reg;
    logic                             zero_reg;

    // output slot
    logic                             out_valid_reg;
    logic [rgbrms_pkg::RMS_W-1:0]     rms_reg;
    logic [rgbrms_pkg::DIST_W-1:0]    peak_out_reg;
    logic [rgbrms_pkg::PAIRS_W-1:0]   pairs_out_reg;
    logic                             no_overlap_reg;

    logic [rgbrms_pkg::DIST_W-1:0]    pair_dist;
    logic [rgbrms_pkg::SUM_W:0]       sum_wide;
    logic [rgbrms_pkg::SUM_W-1:0]     sum_next;
    logic                             pairs_room;
    logic [rgbrms_pkg::DIVISOR_W:0]   div_sh;
    logic                             div_ge;
    logic [rgbrms_pkg::SQREM_W+1:0]   sq_sh;
    logic [rgbrms_pkg::SQREM_W+1:0]   sq_trial;
    logic                             sq_ge;
    logic [rgbrms_pkg::RMS_W-1:0]     rms_next;

    assign pair_dist = rgbrms_pkg::DIST_W'(chan_sq(red_a, red_b))
                     + rgbrms_pkg::DIST_W'(chan_sq(green_a, green_b))
                     + rgbrms_pkg::DIST_W'(chan_sq(blue_a, blue_b));

    assign sum_wide   = {1'b0, sum_reg} + (rgbrms_pkg::SUM_W + 1)'(pair_dist);
    assign sum_next   = sum_wide[rgbrms_pkg::SUM_W] ? '1 : sum_wide[rgbrms_pkg::SUM_W-1:0];
    assign pairs_room = pairs_reg < rgbrms_pkg::PAIRS_W'(rgbrms_pkg::PAIR_CAP);

    // restoring divide: one quotient bit a step, shifted in behind the numerator
    assign div_sh = {div_rem_reg, nq_reg[rgbrms_pkg::NUM_W-1]};
    assign div_ge = div_sh >= {1'b0, divisor_reg};

    // digit-by-digit root: two radicand bits in and one root bit out a step
    assign sq_sh    = {sq_rem_reg, nq_reg[rgbrms_pkg::NUM_W-1 -: 2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    assign rms_next = zero_reg ? rgbrms_pkg::RMS_W'(rgbrms_pkg::FULL_SCALE)
                    : (root_reg > rgbrms_pkg::ROOT_W'(rgbrms_pkg::FULL_SCALE))
                      ? rgbrms_pkg::RMS_W'(rgbrms_pkg::FULL_SCALE)
                      : root_reg[rgbrms_pkg::RMS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            peak_reg  <= '0;
            pairs_reg <= '0;
        end
        else if (cmd.capture)
        begin
            sum_reg   <= '0;
            peak_reg  <= '0;
            pairs_reg <= '0;
        end
        else if (cmd.accumulate && pairs_room)
        begin
            sum_reg   <= sum_next;
            pairs_reg <= pairs_reg + 1'b1;
            if (pair_dist > peak_reg)
            begin
                peak_reg <= pair_dist;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            nq_reg         <= {sum_reg, 16'h0000};
            divisor_reg    <= {1'b0, pairs_reg, 1'b0} + {2'b00, pairs_reg};
            div_rem_reg    <= '0;
            root_reg       <= '0;
            sq_rem_reg     <= '0;
            peak_hold_reg  <= peak_reg;
            pairs_hold_reg <= pairs_reg;
            zero_reg       <= (pairs_reg == '0);
        end
        else if (cmd.div_step)
        begin
            nq_reg <= {nq_reg[rgbrms_pkg::NUM_W-2:0], div_ge};
            div_rem_reg <= div_ge ? rgbrms_pkg::DIVISOR_W'(div_sh - {1'b0, divisor_reg})
                                  : div_sh[rgbrms_pkg::DIVISOR_W-1:0];
        end
        else if (cmd.root_step)
        begin
            nq_reg     <= {nq_reg[rgbrms_pkg::NUM_W-3:0], 2'b00};
            root_reg   <= {root_reg[rgbrms_pkg::ROOT_W-2:0], sq_ge};
            sq_rem_reg <= sq_ge ? rgbrms_pkg::SQREM_W'(sq_sh - sq_trial)
                                : sq_sh[rgbrms_pkg::SQREM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rms_reg        <= rms_next;
            peak_out_reg   <= zero_reg ? '0 : peak_hold_reg;
            pairs_out_reg  <= zero_reg ? '0 : pairs_hold_reg;
            no_overlap_reg <= zero_reg;
        end
    end

    assign sts.pairs_zero = (pairs_reg == '0);
    assign sts.out_busy   = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign rms_scaled   = rms_reg;
    assign peak_sq_dist = peak_out_reg;
    assign pair_count   = pairs_out_reg;
    assign no_overlap   = no_overlap_reg;

`ifndef SYNTH
    a_pairs_cap: assert property (@(posedge clk) disable iff (!rst_n)
        pairs_reg <= rgbrms_pkg::PAIRS_W'(rgbrms_pkg::PAIR_CAP))
        else $error("pair count beyond capacity");

    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg <= rgbrms_pkg::DIST_W'(rgbrms_pkg::DIST_MAX))
        else $error("peak distance out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("pending result overwritten");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (pairs_reg == '0) && (sum_reg == '0) && (peak_reg == '0))
        else $error("accumulators not cleared after frame");
`endif

endmodule

### design/rgbrms_ctrl.sv
// Controller: frame accumulation, divide and root sequencing, result hand-off.
`timescale 1ns / 1ps
module rgbrms_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  compare,
    input  logic                  last,
    input  rgbrms_pkg::sts_t      sts,
    output rgbrms_pkg::cmd_t      cmd
);

    rgbrms_pkg::state_t            state_reg;
    rgbrms_pkg::state_t            state_next;
    logic [rgbrms_pkg::CNT_W-1:0]  cnt_reg;
    logic [rgbrms_pkg::CNT_W-1:0]  cnt_next;
    logic                          accept;

    assign in_ready = (state_reg == rgbrms_pkg::ST_ACC);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rgbrms_pkg::ST_ACC;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            rgbrms_pkg::ST_ACC:
            begin
                cmd.accumulate = accept && compare;
                if (accept && last)
                begin
                    state_next = rgbrms_pkg::ST_LOAD;
                end
            end
            rgbrms_pkg::ST_LOAD:
            begin
                cmd.capture = 1'b1;
                cnt_next    = '0;
                // empty frame skips the arithmetic entirely
                state_next  = sts.pairs_zero ? rgbrms_pkg::ST_OUT : rgbrms_pkg::ST_DIV;
            end
            rgbrms_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == rgbrms_pkg::CNT_W'(rgbrms_pkg::DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = rgbrms_pkg::ST_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rgbrms_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == rgbrms_pkg::CNT_W'(rgbrms_pkg::ROOT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = rgbrms_pkg::ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rgbrms_pkg::ST_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rgbrms_pkg::ST_ACC;
                end
            end
            default:
            begin
                state_next = rgbrms_pkg::ST_ACC;
            end
        endcase
    end

`ifndef SYNTH
    a_load_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (state_reg == rgbrms_pkg::ST_LOAD))
        else $error("last request did not start result");

    a_one_step_kind: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accumulate, cmd.capture, cmd.div_step, cmd.root_step, cmd.out_load}))
        else $error("conflicting datapath commands");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rgbrms_pkg::ST_ROOT)
            |-> (cnt_reg < rgbrms_pkg::CNT_W'(rgbrms_pkg::ROOT_STEPS)))
        else $error("root step count overrun");
`endif

endmodule

### tb/tb_top.sv
// Testbench for the RGB RMS image difference block: directed frames (some with typed results), then random frames.
`timescale 1ns / 1ps
module tb_top;

    typedef struct packed {
        logic [7:0] red_a;
        logic [7:0] green_a;
        logic [7:0] blue_a;
        logic [7:0] red_b;
        logic [7:0] green_b;
        logic [7:0] blue_b;
        logic       compare;
        logic       last;
    } pixel_pair_t;

    typedef struct packed {
        logic [rgbrms_pkg::RMS_W-1:0]   rms;
        logic [rgbrms_pkg::DIST_W-1:0]  peak;
        logic [rgbrms_pkg::PAIRS_W-1:0] count;
        logic                           no_ovl;
    } frame_result_t;

    typedef struct packed {
        pixel_pair_t   px;
        logic          typed;
        frame_result_t res;
    } dir_row_t;

    typedef enum int {
        KIND_NORMAL,
        KIND_NONE,
        KIND_SAME,
        KIND_SPARSE
    } frame_kind_t;

    localparam int NUM_ROWS     = 19;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 400;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic [7:0]                       red_a, green_a, blue_a, red_b, green_b, blue_b;
    logic                             compare;
    logic                             last;
    logic                             out_valid;
    logic                             out_ready;
    logic [rgbrms_pkg::RMS_W-1:0]     rms_scaled;
    logic [rgbrms_pkg::DIST_W-1:0]    peak_sq_dist;
    logic [rgbrms_pkg::PAIRS_W-1:0]   pair_count;
    logic                             no_overlap;

    // running frame state of the predictor
    logic [rgbrms_pkg::SUM_W-1:0]     acc_sum;
    logic [rgbrms_pkg::DIST_W-1:0]    acc_peak;
    logic [rgbrms_pkg::PAIRS_W-1:0]   acc_pairs;

    frame_result_t       pending_frames [$];
    int                  items_sent;
    int                  frames_sent;
    int                  frames_checked;
    int                  empty_frames;
    int                  mismatches;
    bit                  calm;
    bit                  hold_req;

    dir_row_t dir_rows [NUM_ROWS] = '{
        // empty frame right after reset
        '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}, 1'b1,
          '{16'd65280, 18'd0, 21'd0, 1'b1}},
        // full-scale difference, both directions
        '{'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1}, 1'b1,
          '{16'd65280, 18'd195075, 21'd1, 1'b0}},
        '{'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1}, 1'b1,
          '{16'd65280, 18'd195075, 21'd1, 1'b0}},
        // identical pixels
        '{'{8'd170, 8'd85, 8'd60, 8'd170, 8'd85, 8'd60, 1'b1, 1'b1}, 1'b1,
          '{16'd0, 18'd0, 21'd1, 1'b0}},
        // one channel at a time
        '{'{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1}, 1'b0, '0},
        // mixed frame, skipped pairs must not count
        '{'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd12, 8'd200, 8'd7, 8'd30, 8'd180, 8'd99, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 1'b0, 1'b1}, 1'b0, '0},
        // frame with nothing compared
        '{'{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd85, 8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1}, 1'b1,
          '{16'd65280, 18'd0, 21'd0, 1'b1}},
        // identical images over two pairs
        '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1}, 1'b1,
          '{16'd0, 18'd0, 21'd2, 1'b0}},
        // peak comes early, then a small pair
        '{'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11, 1'b1, 1'b1}, 1'b0, '0}
    };

    rgb_rms_image_difference uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .red_a        (red_a),
        .green_a      (green_a),
        .blue_a       (blue_a),
        .red_b        (red_b),
        .green_b      (green_b),
        .blue_b       (blue_b),
        .compare      (compare),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rms_scaled   (rms_scaled),
        .peak_sq_dist (peak_sq_dist),
        .pair_count   (pair_count),
        .no_overlap   (no_overlap)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        // q stays below 2^54, so the root fits in 28 bits
        for (int i = 27; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= v)
                root = trial;
        end
        return root[31:0];
    endfunction

    // Fold a compared pair into the frame accumulators; report a result on last.
    task automatic fold_pixel_pair(input pixel_pair_t p, output bit produced,
                                   output frame_result_t res);
        int          dr, dg, db, pair_sq;
        logic [63:0] s, num, den, q;
        logic [31:0] root;
        if (p.compare && acc_pairs < rgbrms_pkg::PAIR_CAP)
        begin
            dr      = int'(p.red_a) - int'(p.red_b);
            dg      = int'(p.green_a) - int'(p.green_b);
            db      = int'(p.blue_a) - int'(p.blue_b);
            pair_sq = dr * dr + dg * dg + db * db;
            s       = 64'(acc_sum) + 64'(pair_sq);
            acc_sum = (s > {rgbrms_pkg::SUM_W{1'b1}}) ? {rgbrms_pkg::SUM_W{1'b1}}
                                                      : s[rgbrms_pkg::SUM_W-1:0];
            if (pair_sq > int'(acc_peak))
                acc_peak = pair_sq[rgbrms_pkg::DIST_W-1:0];
            acc_pairs++;
        end
        produced = p.last;
        res      = '0;
        if (p.last)
        begin
            if (acc_pairs == 0)
            begin
                res.rms    = rgbrms_pkg::RMS_W'(rgbrms_pkg::FULL_SCALE);
                res.no_ovl = 1'b1;
            end
            else
            begin
                num  = 64'(acc_sum) << 16;
                den  = 64'(acc_pairs) * 3;
                q    = num / den;
                root = floor_sqrt(q);
                if (root > rgbrms_pkg::FULL_SCALE)
                    root = rgbrms_pkg::FULL_SCALE;
                res.rms   = root[rgbrms_pkg::RMS_W-1:0];
                res.peak  = acc_peak;
                res.count = acc_pairs;
            end
            acc_sum   = '0;
            acc_peak  = '0;
            acc_pairs = '0;
        end
    endtask

    task automatic offer_pair(input pixel_pair_t p, input bit typed,
                              input frame_result_t typed_res);
        bit            produced;
        frame_result_t res;
        if (!calm)
        begin
            while ($urandom_range(99) < 17)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        red_a    <= p.red_a;
        green_a  <= p.green_a;
        blue_a   <= p.blue_a;
        red_b    <= p.red_b;
        green_b  <= p.green_b;
        blue_b   <= p.blue_b;
        compare  <= p.compare;
        last     <= p.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        fold_pixel_pair(p, produced, res);
        if (produced)
        begin
            frames_sent++;
            pending_frames.push_back(typed ? typed_res : res);
        end
    endtask

    function automatic logic [7:0] pick_chan();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_pair_t make_pair(input frame_kind_t kind, input bit is_last);
        pixel_pair_t p;
        p.red_a   = pick_chan();
        p.green_a = pick_chan();
        p.blue_a  = pick_chan();
        if (kind == KIND_SAME)
        begin
            p.red_b   = p.red_a;
            p.green_b = p.green_a;
            p.blue_b  = p.blue_a;
        end
        else if ($urandom_range(99) < 30)
        begin
            // near match, small differences
            p.red_b   = p.red_a + 8'($urandom_range(8)) - 8'd4;
            p.green_b = p.green_a + 8'($urandom_range(8)) - 8'd4;
            p.blue_b  = p.blue_a + 8'($urandom_range(8)) - 8'd4;
        end
        else
        begin
            p.red_b   = pick_chan();
            p.green_b = pick_chan();
            p.blue_b  = pick_chan();
        end
        case (kind)
            KIND_NONE:   p.compare = 1'b0;
            KIND_SAME:   p.compare = 1'b1;
            KIND_SPARSE: p.compare = ($urandom_range(1) == 1);
            default:     p.compare = ($urandom_range(99) < 85);
        endcase
        p.last = is_last;
        return p;
    endfunction

    // result monitor
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: rms %0d peak %0d count %0d no_overlap %0d",
                             rms_scaled, peak_sq_dist, pair_count, no_overlap);
            end
            else
            begin
                want = pending_frames.pop_front();
                frames_checked++;
                if (rms_scaled !== want.rms || peak_sq_dist !== want.peak ||
                    pair_count !== want.count || no_overlap !== want.no_ovl)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"frame %0d: exp rms %0d peak %0d count %0d no_ovl %0d, ",
                                  "got %0d %0d %0d %0d"},
                                 frames_checked, want.rms, want.peak, want.count,
                                 want.no_ovl, rms_scaled, peak_sq_dist, pair_count,
                                 no_overlap);
                end
                if (want.no_ovl)
                    empty_frames++;
            end
        end
    end

    // result receiver, with one long hold-off once the random part asks for it
    initial
    begin
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                out_ready  <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 17);
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int          len, sel, rnd_start;
        frame_kind_t kind;
        pixel_pair_t p;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        red_a     = '0;
        green_a   = '0;
        blue_a    = '0;
        red_b     = '0;
        green_b   = '0;
        blue_b    = '0;
        compare   = 1'b0;
        last      = 1'b0;
        acc_sum   = '0;
        acc_peak  = '0;
        acc_pairs = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer_pair(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].res);

        rnd_start = items_sent;
        while (items_sent - rnd_start < RANDOM_ITEMS)
        begin
            if (items_sent - rnd_start >= 300)
                hold_req = 1'b1;
            // short frames while the receiver is held off, to back the block up
            if (items_sent - rnd_start >= 300 && items_sent - rnd_start < 360)
                len = $urandom_range(1, 2);
            else
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                    len = $urandom_range(1, 24);
                else if (sel < 90)
                    len = $urandom_range(25, 60);
                else
                    len = 1;
            end
            sel = $urandom_range(99);
            if (sel < 6)
                kind = KIND_NONE;
            else if (sel < 12)
                kind = KIND_SAME;
            else if (sel < 22)
                kind = KIND_SPARSE;
            else
                kind = KIND_NORMAL;
            for (int i = 0; i < len; i++)
            begin
                calm = (items_sent - rnd_start >= 1200) && (items_sent - rnd_start < 1500);
                p = make_pair(kind, i == len - 1);
                offer_pair(p, 1'b0, '0);
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Sent %0d pixel pairs in %0d frames, checked %0d results (%0d with no overlap).",
                 items_sent, frames_sent, frames_checked, empty_frames);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### rgb_rms_image_difference.f
design/rgbrms_pkg.sv
design/rgbrms_dp.sv
design/rgbrms_ctrl.sv
design/rgb_rms_image_difference.sv
tb/tb_top.sv
